[sv/tmre_pkg.sv]
`timescale 1ns / 1ps

package tmre_pkg;

  // Field and register widths.
  localparam int PIX_BITS      = 12;
  localparam int KIND_BITS     = 3;
  localparam int BTN_BITS      = 4;
  localparam int PAD_BITS      = 8;
  localparam int SIZE_BITS     = 7;
  localparam int CODE_BITS     = 7;
  localparam int DEC_BITS      = 14;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 8;

  // The cell divider retires one quotient bit per step.
  localparam int DIV_STEPS     = PIX_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

  // Event kinds.
  localparam logic [KIND_BITS-1:0] KIND_LEFT_PRESS   = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_LEFT_RELEASE = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_OTHER_BUTTON = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_MOTION       = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_WHEEL        = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRACKING    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SGR_FORMAT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAD_LEFT    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAD_TOP     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CELL_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CELL_HEIGHT = 3'd5;

  // Tracking levels.
  localparam logic [1:0] TRK_OFF    = 2'd0;
  localparam logic [1:0] TRK_NORMAL = 2'd1;
  localparam logic [1:0] TRK_BUTTON = 2'd2;
  localparam logic [1:0] TRK_ANY    = 2'd3;

  // Register reset values.
  localparam logic [SIZE_BITS-1:0] CELL_WIDTH_RST  = 7'd9;
  localparam logic [SIZE_BITS-1:0] CELL_HEIGHT_RST = 7'd18;

  // Report codes.
  localparam logic [CODE_BITS-1:0] CODE_LEFT        = 7'd0;
  localparam logic [CODE_BITS-1:0] CODE_MOTION_BASE = 7'd32;
  localparam logic [CODE_BITS-1:0] CODE_MOTION_NONE = 7'd35;
  localparam logic [CODE_BITS-1:0] CODE_WHEEL_UP    = 7'd64;
  localparam logic [CODE_BITS-1:0] CODE_WHEEL_DOWN  = 7'd65;
  localparam logic [7:0]           CODE_LEGACY_REL  = 8'd3;
  localparam logic [7:0]           LEGACY_OFFSET    = 8'd32;
  localparam logic [DEC_BITS-1:0]  SGR_MAX          = 14'd9999;

  // Characters of the escape sequence.
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_UPPER_M = 8'h4D;
  localparam logic [7:0] CH_LOWER_M = 8'h6D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_ZERO    = 8'h30;

  // Which decimal number the SGR emitter is working on.
  typedef enum logic [1:0] {
    NUM_CODE = 2'd0,
    NUM_X    = 2'd1,
    NUM_Y    = 2'd2
  } num_sel_t;

  // Source of the next output byte.
  typedef enum logic [3:0] {
    B_ESC     = 4'd0,
    B_BRACKET = 4'd1,
    B_LT      = 4'd2,
    B_UPPER_M = 4'd3,
    B_SEMI    = 4'd4,
    B_FINAL   = 4'd5,
    B_DIGIT   = 4'd6,
    B_LCODE   = 4'd7,
    B_LX      = 4'd8,
    B_LY      = 4'd9
  } byte_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       div_step;
    logic       commit;
    logic       num_load;
    num_sel_t   num_sel;
    logic       digit_step;
    logic [1:0] digit_pos;
    logic       out_load;
    byte_sel_t  byte_sel;
    logic       out_last;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic report_en;
    logic sgr;
    logic digit_zero;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [3:0]          digit;
    logic [DEC_BITS-1:0] sub;
  } dec_digit_t;

  // Weight of a decimal digit position, thousands first.
  function automatic logic [DEC_BITS-1:0] pow10(logic [1:0] pos);
    logic [DEC_BITS-1:0] p;
    unique case (pos)
      2'd0:    p = 14'd1000;
      2'd1:    p = 14'd100;
      2'd2:    p = 14'd10;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

  // One decimal digit of v at a position, and the amount to take off v.
  function automatic dec_digit_t dec_digit(logic [DEC_BITS-1:0] v, logic [1:0] pos);
    dec_digit_t          res;
    logic [DEC_BITS-1:0] p;
    logic [17:0]         m;
    p         = pow10(pos);
    res.digit = '0;
    res.sub   = '0;
    for (int k = 1; k <= 9; k++) begin
      m = 18'(k) * 18'(p);
      if (18'(v) >= m) begin
        res.digit = 4'(k);
        res.sub   = m[DEC_BITS-1:0];
      end
    end
    return res;
  endfunction

endpackage

[sv/tmre_channels.sv]
`timescale 1ns / 1ps

// Pointer event channel.
interface tmre_event_if;
  logic                             valid;
  logic                             ready;
  logic [tmre_pkg::KIND_BITS-1:0]   kind;
  logic [tmre_pkg::PIX_BITS-1:0]    pixel_x;
  logic [tmre_pkg::PIX_BITS-1:0]    pixel_y;
  logic [tmre_pkg::BTN_BITS-1:0]    button;
  logic                             pressed;
  logic                             wheel_up;

  modport source (output valid, kind, pixel_x, pixel_y, button, pressed, wheel_up,
                  input ready);
  modport sink   (input valid, kind, pixel_x, pixel_y, button, pressed, wheel_up,
                  output ready);
endinterface

// Report byte channel.
interface tmre_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       last_byte;

  modport source (output valid, report_byte, last_byte, input ready);
  modport sink   (input valid, report_byte, last_byte, output ready);
endinterface

[sv/terminal_mouse_report_encoder.sv]
`timescale 1ns / 1ps

// Terminal mouse report encoder.
// Pointer events arrive on the ev channel (valid/ready); each accepted transaction
// may produce one escape-sequence report, sent one byte per transaction on the rpt
// channel, with last_byte set on the final byte. Registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is idle,
// as the block itself does not enforce it. After an event is accepted, the 12-step
// cell divider (one quotient bit per cycle for both axes) runs, then a commit state
// updates the pointer state. A legacy report then sends 6 bytes; an SGR report sends
// 9 to 16 bytes, and each suppressed leading zero takes a digit step with no byte. No
// new event is accepted before the final byte of a report is loaded; the output
// register then lets the next event be accepted while the final byte waits.
// When the receiver stalls, the byte in the output register holds and the sequence
// pauses. Reset (rst, synchronous) restores the register defaults, clears the last
// cell and the held button and drops any report under way.
module terminal_mouse_report_encoder #(
  parameter int COORD_BITS   = 12,
  parameter int LEGACY_CLAMP = 223
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tmre_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tmre_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  tmre_event_if.sink                          ev,
  tmre_report_if.source                       rpt
);
  import tmre_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  tmre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ev.valid),
    .in_ready (ev.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tmre_datapath #(
    .COORD_BITS   (COORD_BITS),
    .LEGACY_CLAMP (LEGACY_CLAMP)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .kind      (ev.kind),
    .pixel_x   (ev.pixel_x),
    .pixel_y   (ev.pixel_y),
    .button    (ev.button),
    .pressed   (ev.pressed),
    .wheel_up  (ev.wheel_up),
    .cmd       (cmd),
    .status    (status),
    .out_ready (rpt.ready),
    .out_valid (rpt.valid),
    .out_byte  (rpt.report_byte),
    .out_last  (rpt.last_byte)
  );

endmodule

[sv/tmre_ctrl.sv]
`timescale 1ns / 1ps

module tmre_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tmre_pkg::dp_status_t status,
  output tmre_pkg::ctl_cmd_t   cmd
);
  import tmre_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_DIVIDE = 12'b0000_0000_0010,
    ST_COMMIT = 12'b0000_0000_0100,
    ST_ESC    = 12'b0000_0000_1000,
    ST_BRKT   = 12'b0000_0001_0000,
    ST_LEAD   = 12'b0000_0010_0000,
    ST_S_NUM  = 12'b0000_0100_0000,
    ST_S_SEP  = 12'b0000_1000_0000,
    ST_S_END  = 12'b0001_0000_0000,
    ST_L_CODE = 12'b0010_0000_0000,
    ST_L_X    = 12'b0100_0000_0000,
    ST_L_Y    = 12'b1000_0000_0000
  } state_t;

  state_t                  state, state_next;
  logic [DIV_CNT_BITS-1:0] div_cnt, div_cnt_next;
  logic [1:0]              pos, pos_next;
  num_sel_t                num_idx, num_idx_next;
  logic                    started, started_next;
  logic                    emit_digit;

  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);
  localparam logic [1:0]              POS_UNITS = 2'd3;

  assign in_ready = (state == ST_IDLE);

  // A digit goes out unless it is a leading zero; the units digit always goes out.
  assign emit_digit = !status.digit_zero || started || (pos == POS_UNITS);

  // Next state and commands.
  always_comb begin
    state_next     = state;
    div_cnt_next   = div_cnt;
    pos_next       = pos;
    num_idx_next   = num_idx;
    started_next   = started;
    cmd            = '0;
    cmd.num_sel    = num_idx;
    cmd.digit_pos  = pos;
    cmd.byte_sel   = B_ESC;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture  = 1'b1;
          div_cnt_next = '0;
          state_next   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = status.report_en ? ST_ESC : ST_IDLE;
      end
      ST_ESC: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.byte_sel = B_ESC;
          state_next   = ST_BRKT;
        end
      end
      ST_BRKT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.byte_sel = B_BRACKET;
          state_next   = ST_LEAD;
        end
      end
      ST_LEAD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.sgr) begin
            cmd.byte_sel = B_LT;
            cmd.num_load = 1'b1;
            cmd.num_sel  = NUM_CODE;
            num_idx_next = NUM_CODE;
            pos_next     = '0;
            started_next = 1'b0;
            state_next   = ST_S_NUM;
          end else begin
            cmd.byte_sel = B_UPPER_M;
            state_next   = ST_L_CODE;
          end
        end
      end
      ST_S_NUM: begin
        if (!emit_digit || status.out_free) begin
          cmd.out_load   = emit_digit;
          cmd.byte_sel   = B_DIGIT;
          cmd.digit_step = 1'b1;
          started_next   = started | emit_digit;
          pos_next       = pos + 1'b1;
          if (pos == POS_UNITS) begin
            state_next = (num_idx == NUM_Y) ? ST_S_END : ST_S_SEP;
          end
        end
      end
      ST_S_SEP: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.byte_sel = B_SEMI;
          cmd.num_load = 1'b1;
          unique case (num_idx)
            NUM_CODE: num_idx_next = NUM_X;
            default:  num_idx_next = NUM_Y;
          endcase
          cmd.num_sel  = num_idx_next;
          pos_next     = '0;
          started_next = 1'b0;
          state_next   = ST_S_NUM;
        end
      end
      ST_S_END: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.byte_sel = B_FINAL;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_L_CODE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.byte_sel = B_LCODE;
          state_next   = ST_L_X;
        end
      end
      ST_L_X: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.byte_sel = B_LX;
          state_next   = ST_L_Y;
        end
      end
      ST_L_Y: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.byte_sel = B_LY;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Controller registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
      pos     <= '0;
      num_idx <= NUM_CODE;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
      pos     <= pos_next;
      num_idx <= num_idx_next;
      started <= started_next;
    end
  end

endmodule

[sv/tmre_datapath.sv]
`timescale 1ns / 1ps

module tmre_datapath #(
  parameter int COORD_BITS   = 12,
  parameter int LEGACY_CLAMP = 223
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tmre_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tmre_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [tmre_pkg::KIND_BITS-1:0]       kind,
  input  logic [tmre_pkg::PIX_BITS-1:0]        pixel_x,
  input  logic [tmre_pkg::PIX_BITS-1:0]        pixel_y,
  input  logic [tmre_pkg::BTN_BITS-1:0]        button,
  input  logic                                 pressed,
  input  logic                                 wheel_up,
  input  tmre_pkg::ctl_cmd_t                   cmd,
  output tmre_pkg::dp_status_t                 status,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [7:0]                           out_byte,
  output logic                                 out_last
);
  import tmre_pkg::*;

  localparam int             WIDE_BITS = 17;
  localparam logic [WIDE_BITS-1:0] MAX_CELL =
      WIDE_BITS'((32'd1 << COORD_BITS) - 32'd1);
  localparam logic [WIDE_BITS-1:0] CLAMP_W = WIDE_BITS'(LEGACY_CLAMP);

  // Configuration registers.
  logic [1:0]           trk;
  logic                 sgr;
  logic [PAD_BITS-1:0]  pad_left, pad_top;
  logic [SIZE_BITS-1:0] cell_width, cell_height;

  // Captured event.
  logic [KIND_BITS-1:0] kind_q;
  logic [BTN_BITS-1:0]  btn_q;
  logic                 pressed_q;
  logic                 wheel_q;

  // Two restoring dividers, one per axis.
  logic [PIX_BITS-1:0]  qx, qy;
  logic [SIZE_BITS-1:0] rx, ry, dx, dy;

  // Pointer state.
  logic [COORD_BITS-1:0] last_column, last_row_cell;
  logic                  held_valid;
  logic [BTN_BITS-1:0]   held_number;

  // Report under way.
  logic [CODE_BITS-1:0] code_q;
  logic                 press_q;
  logic [DEC_BITS-1:0]  sgr_x, sgr_y;
  logic [7:0]           leg_code, leg_x, leg_y;
  logic [DEC_BITS-1:0]  num_work;

  // Commit-time signals.
  logic [COORD_BITS-1:0] col_new, row_new, rep_col, rep_row;
  logic [WIDE_BITS-1:0]  qx_w, qy_w, x_w, y_w;
  logic                  rep_en, rep_press, upd_cell, held_valid_next;
  logic [BTN_BITS-1:0]   held_number_next;
  logic [CODE_BITS-1:0]  rep_code;
  logic                  trk_on;
  dec_digit_t            dec;
  logic [7:0]            byte_next;

  // Offsets into the cell grid; a position inside the padding gives zero.
  logic [PIX_BITS-1:0] off_x, off_y;
  assign off_x = (pixel_x >= PIX_BITS'(pad_left)) ? pixel_x - PIX_BITS'(pad_left) : '0;
  assign off_y = (pixel_y >= PIX_BITS'(pad_top))  ? pixel_y - PIX_BITS'(pad_top)  : '0;

  function automatic logic [SIZE_BITS+PIX_BITS-1:0] div_bit(
      logic [SIZE_BITS-1:0] r, logic [PIX_BITS-1:0] q, logic [SIZE_BITS-1:0] d);
    logic [SIZE_BITS:0]   r2;
    logic                 ge;
    logic [SIZE_BITS-1:0] r_new;
    r2    = {r, q[PIX_BITS-1]};
    ge    = (r2 >= {1'b0, d});
    r_new = ge ? SIZE_BITS'(r2 - {1'b0, d}) : r2[SIZE_BITS-1:0];
    return {r_new, q[PIX_BITS-2:0], ge};
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      trk         <= TRK_OFF;
      sgr         <= 1'b0;
      pad_left    <= '0;
      pad_top     <= '0;
      cell_width  <= CELL_WIDTH_RST;
      cell_height <= CELL_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRACKING:    trk         <= cfg_data[1:0];
        CFG_SGR_FORMAT:  sgr         <= cfg_data[0];
        CFG_PAD_LEFT:    pad_left    <= cfg_data[PAD_BITS-1:0];
        CFG_PAD_TOP:     pad_top     <= cfg_data[PAD_BITS-1:0];
        CFG_CELL_WIDTH:  cell_width  <= cfg_data[SIZE_BITS-1:0];
        CFG_CELL_HEIGHT: cell_height <= cfg_data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Event capture and division.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q    <= kind;
      btn_q     <= button;
      pressed_q <= pressed;
      wheel_q   <= wheel_up;
      qx        <= off_x;
      qy        <= off_y;
      rx        <= '0;
      ry        <= '0;
      dx        <= (cell_width  == '0) ? SIZE_BITS'(1) : cell_width;
      dy        <= (cell_height == '0) ? SIZE_BITS'(1) : cell_height;
    end else if (cmd.div_step) begin
      {rx, qx} <= div_bit(rx, qx, dx);
      {ry, qy} <= div_bit(ry, qy, dy);
    end
  end

  // Cells saturate at the coordinate width.
  assign qx_w    = WIDE_BITS'(qx);
  assign qy_w    = WIDE_BITS'(qy);
  assign col_new = (qx_w > MAX_CELL) ? MAX_CELL[COORD_BITS-1:0] : qx_w[COORD_BITS-1:0];
  assign row_new = (qy_w > MAX_CELL) ? MAX_CELL[COORD_BITS-1:0] : qy_w[COORD_BITS-1:0];
  assign trk_on  = (trk != TRK_OFF);

  // Event decode: what to report and how the pointer state changes.
  always_comb begin
    rep_en           = 1'b0;
    rep_code         = CODE_LEFT;
    rep_press        = 1'b1;
    rep_col          = last_column;
    rep_row          = last_row_cell;
    upd_cell         = 1'b0;
    held_valid_next  = held_valid;
    held_number_next = held_number;
    unique case (kind_q)
      KIND_LEFT_PRESS: begin
        upd_cell         = 1'b1;
        held_valid_next  = 1'b1;
        held_number_next = '0;
        rep_col          = col_new;
        rep_row          = row_new;
        rep_en           = trk_on;
      end
      KIND_LEFT_RELEASE: begin
        held_valid_next  = 1'b0;
        held_number_next = '0;
        rep_press        = 1'b0;
        rep_en           = trk_on;
      end
      KIND_OTHER_BUTTON: begin
        upd_cell = 1'b1;
        rep_col  = col_new;
        rep_row  = row_new;
        rep_code = CODE_BITS'(btn_q);
        rep_press = pressed_q;
        if (trk_on) begin
          held_valid_next  = pressed_q;
          held_number_next = pressed_q ? btn_q : '0;
          rep_en           = 1'b1;
        end
      end
      KIND_MOTION: begin
        upd_cell = 1'b1;
        rep_col  = col_new;
        rep_row  = row_new;
        rep_code = held_valid ? CODE_MOTION_BASE + CODE_BITS'(held_number)
                              : CODE_MOTION_NONE;
        rep_en   = (trk == TRK_ANY) || ((trk == TRK_BUTTON) && held_valid);
      end
      KIND_WHEEL: begin
        rep_code = wheel_q ? CODE_WHEEL_UP : CODE_WHEEL_DOWN;
        rep_en   = trk_on;
      end
      default: begin
        rep_en = 1'b0;
      end
    endcase
  end

  // One-based coordinates for both report forms.
  assign x_w = WIDE_BITS'(rep_col) + WIDE_BITS'(1);
  assign y_w = WIDE_BITS'(rep_row) + WIDE_BITS'(1);

  // Commit the pointer state and latch the report.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_column   <= '0;
      last_row_cell <= '0;
      held_valid    <= 1'b0;
      held_number   <= '0;
    end else if (cmd.commit) begin
      if (upd_cell) begin
        last_column   <= col_new;
        last_row_cell <= row_new;
      end
      held_valid  <= held_valid_next;
      held_number <= held_number_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      code_q   <= rep_code;
      press_q  <= rep_press;
      sgr_x    <= (x_w > WIDE_BITS'(SGR_MAX)) ? SGR_MAX : x_w[DEC_BITS-1:0];
      sgr_y    <= (y_w > WIDE_BITS'(SGR_MAX)) ? SGR_MAX : y_w[DEC_BITS-1:0];
      leg_code <= LEGACY_OFFSET + (rep_press ? 8'(rep_code) : CODE_LEGACY_REL);
      leg_x    <= LEGACY_OFFSET + ((x_w > CLAMP_W) ? CLAMP_W[7:0] : x_w[7:0]);
      leg_y    <= LEGACY_OFFSET + ((y_w > CLAMP_W) ? CLAMP_W[7:0] : y_w[7:0]);
    end
  end

  // Decimal conversion, one digit per step.
  assign dec = dec_digit(num_work, cmd.digit_pos);

  always_ff @(posedge clk) begin
    if (cmd.num_load) begin
      unique case (cmd.num_sel)
        NUM_CODE: num_work <= DEC_BITS'(code_q);
        NUM_X:    num_work <= sgr_x;
        default:  num_work <= sgr_y;
      endcase
    end else if (cmd.digit_step) begin
      num_work <= num_work - dec.sub;
    end
  end

  // Output byte selection.
  always_comb begin
    unique case (cmd.byte_sel)
      B_ESC:     byte_next = CH_ESC;
      B_BRACKET: byte_next = CH_BRACKET;
      B_LT:      byte_next = CH_LT;
      B_UPPER_M: byte_next = CH_UPPER_M;
      B_SEMI:    byte_next = CH_SEMI;
      B_FINAL:   byte_next = press_q ? CH_UPPER_M : CH_LOWER_M;
      B_DIGIT:   byte_next = CH_ZERO + 8'(dec.digit);
      B_LCODE:   byte_next = leg_code;
      B_LX:      byte_next = leg_x;
      B_LY:      byte_next = leg_y;
      default:   byte_next = CH_ESC;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte <= byte_next;
      out_last <= cmd.out_last;
    end
  end

  assign status.report_en  = rep_en;
  assign status.sgr        = sgr;
  assign status.digit_zero = (dec.digit == '0);
  assign status.out_free   = !out_valid || out_ready;

endmodule

[sv/tmre_checker.sv]
`timescale 1ns / 1ps

module tmre_checker (
  input logic       clk,
  input logic       rst,
  input logic       ev_valid,
  input logic       ev_ready,
  input logic       rpt_valid,
  input logic       rpt_ready,
  input logic [7:0] rpt_byte,
  input logic       rpt_last
);

  // A stalled report byte stays offered.
  a_rpt_hold: assert property (@(posedge clk) disable iff (rst)
      rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt_byte) && $stable(rpt_last))
    else $error("report byte dropped or changed while stalled");

  // Reset leaves no report byte pending.
  a_rst_empty: assert property (@(posedge clk) rst |=> !rpt_valid)
    else $error("report byte valid after reset");

  // An accepted event keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
      ev_valid && ev_ready |=> !ev_ready)
    else $error("event accepted while the previous one is in the divider");

  // While a byte other than the final one is offered, no new event is taken.
  a_no_event_mid_report: assert property (@(posedge clk) disable iff (rst)
      rpt_valid && !rpt_last |-> !ev_ready)
    else $error("event channel ready while a report is unfinished");

endmodule

bind terminal_mouse_report_encoder tmre_checker u_tmre_checker (
  .clk       (clk),
  .rst       (rst),
  .ev_valid  (ev.valid),
  .ev_ready  (ev.ready),
  .rpt_valid (rpt.valid),
  .rpt_ready (rpt.ready),
  .rpt_byte  (rpt.report_byte),
  .rpt_last  (rpt.last_byte)
);

[dv/terminal_mouse_report_encoder_test.sv]
`timescale 1ns / 1ps

module terminal_mouse_report_encoder_test;
  import tmre_pkg::*;

  localparam int COORD_BITS      = 12;
  localparam int LEGACY_CLAMP    = 223;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int DRAIN_LIMIT     = 4000;
  localparam int IDLE_CYCLES     = 48;
  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 30;

  // Kinds that the encoder does not define.
  localparam logic [KIND_BITS-1:0] KIND_RESERVED_LO  = 3'd5;
  localparam logic [KIND_BITS-1:0] KIND_RESERVED_MID = 3'd6;
  localparam logic [KIND_BITS-1:0] KIND_RESERVED_HI  = 3'd7;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [PIX_BITS-1:0]  pixel_x;
    logic [PIX_BITS-1:0]  pixel_y;
    logic [BTN_BITS-1:0]  button;
    logic                 pressed;
    logic                 wheel_up;
  } ptr_event_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_last;
  } report_byte_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  tmre_event_if  ev_bus();
  tmre_report_if rpt_bus();

  terminal_mouse_report_encoder #(
    .COORD_BITS  (COORD_BITS),
    .LEGACY_CLAMP(LEGACY_CLAMP)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .ev       (ev_bus.sink),
    .rpt      (rpt_bus.source)
  );

  // Shadow copy of the registers and the pointer state.
  logic [1:0]          trk_level;
  logic                sgr_on;
  logic [PAD_BITS-1:0] pad_x;
  logic [PAD_BITS-1:0] pad_y;
  logic [6:0]          cell_w;
  logic [6:0]          cell_h;
  logic [11:0]         cur_col;
  logic [11:0]         cur_row;
  logic                btn_held;
  logic [3:0]          held_btn;

  logic [7:0]   pending_seq[$];
  report_byte_t report_bytes_due[$];
  report_byte_t want;

  bit no_idle = 1'b0;
  int rpt_stall = 0;
  int n_errors = 0;
  int n_events = 0;
  int n_bytes = 0;
  int n_reports = 0;
  int n_settings = 0;
  int cycle_count = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Random idle length: mostly none or short, a few long.
  function automatic int idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [11:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 12'($urandom_range(0, 300));
      default: return 12'($urandom);
    endcase
  endfunction

  // Padding: the extremes often, any value otherwise.
  function automatic logic [7:0] pick_pad();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Cell size with a random unused top bit; zero and oversize appear now and then.
  function automatic logic [7:0] pick_cell_size();
    logic [6:0] size;
    case ($urandom_range(0, 9))
      0:       size = 7'd0;
      1:       size = 7'd1;
      2:       size = 7'd64;
      3:       size = 7'($urandom_range(65, 127));
      default: size = 7'($urandom_range(1, 64));
    endcase
    return {1'($urandom), size};
  endfunction

  function automatic ptr_event_t make_event(logic [2:0] kind, logic [11:0] px, logic [11:0] py,
                                            logic [3:0] btn, logic pressed, logic wheel_up);
    ptr_event_t e;
    e.kind     = kind;
    e.pixel_x  = px;
    e.pixel_y  = py;
    e.button   = btn;
    e.pressed  = pressed;
    e.wheel_up = wheel_up;
    return e;
  endfunction

  // Pixel to cell: below the padding is cell zero, a zero size counts as one.
  function automatic logic [11:0] pixel_to_cell(logic [11:0] pix, logic [7:0] pad,
                                                logic [6:0] size);
    int unsigned divisor;
    int unsigned q;
    divisor = (size == 0) ? 1 : int'(size);
    if (pix < {4'd0, pad}) return '0;
    q = (int'(pix) - int'(pad)) / divisor;
    if (q > (1 << COORD_BITS) - 1) q = (1 << COORD_BITS) - 1;
    return q[11:0];
  endfunction

  // Decimal digits without leading zeros, saturated to four digits.
  function automatic void put_decimal(int unsigned v);
    int unsigned weight;
    bit          started;
    weight  = 1000;
    started = 1'b0;
    if (v > SGR_MAX) v = SGR_MAX;
    while (weight > 0) begin
      if ((v / weight) != 0 || started || weight == 1) begin
        pending_seq.push_back(CH_ZERO + 8'(v / weight));
        started = 1'b1;
      end
      v      = v % weight;
      weight = weight / 10;
    end
  endfunction

  // Build the escape sequence for one report and queue its bytes.
  function automatic void queue_report(int unsigned code, bit press_flag, logic [11:0] col,
                                       logic [11:0] row);
    int unsigned x;
    int unsigned y;
    x = int'(col) + 1;
    y = int'(row) + 1;
    if (trk_level == TRK_OFF) return;
    pending_seq.delete();
    pending_seq.push_back(CH_ESC);
    pending_seq.push_back(CH_BRACKET);
    if (sgr_on) begin
      pending_seq.push_back(CH_LT);
      put_decimal(code);
      pending_seq.push_back(CH_SEMI);
      put_decimal(x);
      pending_seq.push_back(CH_SEMI);
      put_decimal(y);
      pending_seq.push_back(press_flag ? CH_UPPER_M : CH_LOWER_M);
    end else begin
      if (x > LEGACY_CLAMP) x = LEGACY_CLAMP;
      if (y > LEGACY_CLAMP) y = LEGACY_CLAMP;
      pending_seq.push_back(CH_UPPER_M);
      pending_seq.push_back(LEGACY_OFFSET + (press_flag ? 8'(code) : CODE_LEGACY_REL));
      pending_seq.push_back(LEGACY_OFFSET + 8'(x));
      pending_seq.push_back(LEGACY_OFFSET + 8'(y));
    end
    foreach (pending_seq[i])
      report_bytes_due.push_back('{byte_val: pending_seq[i],
                                   is_last: (i == pending_seq.size() - 1)});
  endfunction

  // Update the pointer state for one accepted event and queue its report.
  function automatic void encode_pointer_event(ptr_event_t e);
    logic [11:0] col;
    logic [11:0] row;
    col = pixel_to_cell(e.pixel_x, pad_x, cell_w);
    row = pixel_to_cell(e.pixel_y, pad_y, cell_h);
    case (e.kind)
      KIND_LEFT_PRESS: begin
        cur_col  = col;
        cur_row  = row;
        btn_held = 1'b1;
        held_btn = '0;
        queue_report(CODE_LEFT, 1'b1, col, row);
      end
      KIND_LEFT_RELEASE: begin
        btn_held = 1'b0;
        held_btn = '0;
        queue_report(CODE_LEFT, 1'b0, cur_col, cur_row);
      end
      KIND_OTHER_BUTTON: begin
        cur_col = col;
        cur_row = row;
        if (trk_level != TRK_OFF) begin
          btn_held = e.pressed;
          held_btn = e.pressed ? e.button : 4'd0;
          queue_report(e.button, e.pressed, col, row);
        end
      end
      KIND_MOTION: begin
        cur_col = col;
        cur_row = row;
        if (trk_level == TRK_ANY)
          queue_report(btn_held ? CODE_MOTION_BASE + held_btn : CODE_MOTION_NONE, 1'b1, col, row);
        else if (trk_level == TRK_BUTTON && btn_held)
          queue_report(CODE_MOTION_BASE + held_btn, 1'b1, col, row);
      end
      KIND_WHEEL: begin
        queue_report(e.wheel_up ? CODE_WHEEL_UP : CODE_WHEEL_DOWN, 1'b1, cur_col, cur_row);
      end
      default: begin
      end
    endcase
  endfunction

  // Offer one event after a random gap and wait for the transaction.
  task automatic send_event(input ptr_event_t e);
    int gap;
    gap = no_idle ? 0 : idle_length();
    if (gap > 0) begin
      ev_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_bus.valid    <= 1'b1;
    ev_bus.kind     <= e.kind;
    ev_bus.pixel_x  <= e.pixel_x;
    ev_bus.pixel_y  <= e.pixel_y;
    ev_bus.button   <= e.button;
    ev_bus.pressed  <= e.pressed;
    ev_bus.wheel_up <= e.wheel_up;
    @(posedge clk);
    while (!ev_bus.ready) @(posedge clk);
    encode_pointer_event(e);
    n_events++;
  endtask

  // Stop offering events, wait for every report byte, then let the block go idle.
  task automatic settle_block();
    int waited;
    waited = 0;
    ev_bus.valid <= 1'b0;
    while (report_bytes_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [7:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TRACKING:    trk_level = data[1:0];
      CFG_SGR_FORMAT:  sgr_on    = data[0];
      CFG_PAD_LEFT:    pad_x     = data;
      CFG_PAD_TOP:     pad_y     = data;
      CFG_CELL_WIDTH:  cell_w    = data[6:0];
      CFG_CELL_HEIGHT: cell_h    = data[6:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] level, input logic [7:0] sgr,
                                input logic [7:0] pl, input logic [7:0] pt,
                                input logic [7:0] cw, input logic [7:0] ch);
    settle_block();
    write_reg(CFG_TRACKING, level);
    write_reg(CFG_SGR_FORMAT, sgr);
    write_reg(CFG_PAD_LEFT, pl);
    write_reg(CFG_PAD_TOP, pt);
    write_reg(CFG_CELL_WIDTH, cw);
    write_reg(CFG_CELL_HEIGHT, ch);
    n_settings++;
  endtask

  // Reset settings: tracking off, so nothing is reported, but the state still moves.
  task automatic test_tracking_off();
    send_event(make_event(KIND_LEFT_PRESS, 12'd100, 12'd200, 4'd0, 1'b1, 1'b0));
    send_event(make_event(KIND_MOTION, 12'd150, 12'd250, 4'd0, 1'b0, 1'b0));
    send_event(make_event(KIND_OTHER_BUTTON, 12'd60, 12'd90, 4'd2, 1'b1, 1'b0));
    send_event(make_event(KIND_WHEEL, 12'd0, 12'd0, 4'd0, 1'b0, 1'b1));
    send_event(make_event(KIND_LEFT_RELEASE, 12'd0, 12'd0, 4'd0, 1'b0, 1'b0));
    send_event(make_event(KIND_RESERVED_LO, 12'hFFF, 12'hFFF, 4'hF, 1'b1, 1'b1));
  endtask

  // Normal tracking in legacy form: clamped coordinates and the generic release code.
  task automatic test_legacy_reports();
    apply_settings({6'd0, TRK_NORMAL}, 8'd0, 8'd0, 8'd0, 8'd9, 8'd18);
    send_event(make_event(KIND_WHEEL, 12'd0, 12'd0, 4'd0, 1'b0, 1'b0));
    send_event(make_event(KIND_LEFT_PRESS, 12'd0, 12'd0, 4'd0, 1'b1, 1'b0));
    send_event(make_event(KIND_LEFT_RELEASE, 12'hFFF, 12'hFFF, 4'd0, 1'b0, 1'b0));
    send_event(make_event(KIND_OTHER_BUTTON, 12'hFFF, 12'hFFF, 4'hF, 1'b1, 1'b0));
    send_event(make_event(KIND_MOTION, 12'd500, 12'd500, 4'd0, 1'b0, 1'b0));
    send_event(make_event(KIND_OTHER_BUTTON, 12'hFFF, 12'hFFF, 4'd2, 1'b0, 1'b0));
    send_event(make_event(KIND_WHEEL, 12'd0, 12'd0, 4'd0, 1'b0, 1'b1));
  endtask

  // SGR form with maximum padding, a zero cell width and an oversize cell height.
  task automatic test_sgr_extremes();
    apply_settings({6'h3F, TRK_ANY}, 8'd1, 8'd255, 8'd255, 8'd0, 8'd127);
    send_event(make_event(KIND_MOTION, 12'd10, 12'd10, 4'd0, 1'b0, 1'b0));
    send_event(make_event(KIND_LEFT_PRESS, 12'hFFF, 12'hFFF, 4'd0, 1'b1, 1'b0));
    send_event(make_event(KIND_MOTION, 12'd1000, 12'd2000, 4'd0, 1'b0, 1'b0));
    send_event(make_event(KIND_RESERVED_MID, 12'd300, 12'd300, 4'd1, 1'b1, 1'b1));
    send_event(make_event(KIND_RESERVED_HI, 12'd0, 12'd0, 4'd0, 1'b0, 1'b0));
    send_event(make_event(KIND_LEFT_RELEASE, 12'd0, 12'd0, 4'd0, 1'b0, 1'b0));
    send_event(make_event(KIND_WHEEL, 12'd0, 12'd0, 4'd0, 1'b0, 1'b1));
    // Button-event tracking reports motion only while a button is down.
    settle_block();
    write_reg(CFG_TRACKING, {6'd0, TRK_BUTTON});
    n_settings++;
    send_event(make_event(KIND_MOTION, 12'd700, 12'd700, 4'd0, 1'b0, 1'b0));
    send_event(make_event(KIND_OTHER_BUTTON, 12'd300, 12'd300, 4'd1, 1'b1, 1'b0));
    send_event(make_event(KIND_MOTION, 12'd400, 12'd400, 4'd0, 1'b0, 1'b0));
    send_event(make_event(KIND_OTHER_BUTTON, 12'd400, 12'd400, 4'd1, 1'b0, 1'b0));
  endtask

  // Random settings per phase; mostly press, drag, release gestures, some noise.
  task automatic test_random_traffic();
    logic [1:0]  lvl;
    logic [11:0] gx;
    logic [11:0] gy;
    logic [3:0]  btn;
    bit          use_left;
    int          moves;
    int          count;
    for (int phase = 0; phase < N_PHASES; phase++) begin
      lvl = (phase < 4) ? 2'(3 - phase) :
            (($urandom_range(0, 7) == 0) ? TRK_OFF : 2'($urandom_range(1, 3)));
      apply_settings({6'($urandom), lvl}, {7'($urandom), 1'($urandom)}, pick_pad(), pick_pad(),
                     pick_cell_size(), pick_cell_size());
      no_idle = (phase % 4 == 2);
      count   = 0;
      while (count < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 3) != 0) begin
          use_left = 1'($urandom);
          btn      = 4'($urandom);
          gx       = random_pixel();
          gy       = random_pixel();
          send_event(make_event(use_left ? KIND_LEFT_PRESS : KIND_OTHER_BUTTON, gx, gy, btn,
                                1'b1, 1'($urandom)));
          moves = $urandom_range(0, 4);
          for (int k = 0; k < moves; k++) begin
            gx = gx + 12'($urandom_range(0, 40));
            gy = gy + 12'($urandom_range(0, 40));
            send_event(make_event(KIND_MOTION, gx, gy, 4'($urandom), 1'($urandom), 1'($urandom)));
          end
          if ($urandom_range(0, 3) == 0)
            send_event(make_event(KIND_WHEEL, random_pixel(), random_pixel(), 4'($urandom),
                                  1'($urandom), 1'($urandom)));
          send_event(make_event(use_left ? KIND_LEFT_RELEASE : KIND_OTHER_BUTTON,
                                random_pixel(), random_pixel(), btn, 1'b0, 1'($urandom)));
          count += moves + 2;
        end else begin
          send_event(make_event(3'($urandom_range(0, 7)), random_pixel(), random_pixel(),
                                4'($urandom), 1'($urandom), 1'($urandom)));
          count++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // Report sink: ready drops for random stretches unless idling is off.
  always @(posedge clk) begin
    if (rpt_stall > 0) begin
      rpt_bus.ready <= 1'b0;
      rpt_stall--;
    end else begin
      rpt_bus.ready <= 1'b1;
      rpt_stall = no_idle ? 0 : idle_length();
    end
  end

  // Compare every report byte transaction with the oldest expected byte.
  always @(posedge clk) begin
    if (!rst && rpt_bus.valid && rpt_bus.ready) begin
      if (report_bytes_due.size() == 0) begin
        $error("Unexpected report byte 0x%02h, last_byte %0b", rpt_bus.report_byte,
               rpt_bus.last_byte);
        n_errors++;
      end else begin
        want = report_bytes_due.pop_front();
        if (rpt_bus.report_byte !== want.byte_val) begin
          $error("report_byte: expected 0x%02h, got 0x%02h", want.byte_val,
                 rpt_bus.report_byte);
          n_errors++;
        end
        if (rpt_bus.last_byte !== want.is_last) begin
          $error("last_byte: expected %0b, got %0b", want.is_last, rpt_bus.last_byte);
          n_errors++;
        end
      end
      n_bytes++;
      if (rpt_bus.last_byte === 1'b1) n_reports++;
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d bytes still expected", cycle_count,
             report_bytes_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main sequence.
  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    ev_bus.valid    = 1'b0;
    ev_bus.kind     = '0;
    ev_bus.pixel_x  = '0;
    ev_bus.pixel_y  = '0;
    ev_bus.button   = '0;
    ev_bus.pressed  = 1'b0;
    ev_bus.wheel_up = 1'b0;
    rpt_bus.ready   = 1'b0;
    trk_level       = TRK_OFF;
    sgr_on          = 1'b0;
    pad_x           = '0;
    pad_y           = '0;
    cell_w          = CELL_WIDTH_RST;
    cell_h          = CELL_HEIGHT_RST;
    cur_col         = '0;
    cur_row         = '0;
    btn_held        = 1'b0;
    held_btn        = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_tracking_off();
    test_legacy_reports();
    test_sgr_extremes();
    test_random_traffic();
    settle_block();

    if (report_bytes_due.size() != 0) begin
      $error("%0d expected report bytes never arrived", report_bytes_due.size());
      n_errors++;
    end
    $display("Covered %0d pointer events under %0d register settings in %0d cycles.",
             n_events, n_settings, cycle_count);
    $display("Checked %0d report bytes forming %0d reports; %0d mismatches.", n_bytes,
             n_reports, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
sv/tmre_pkg.sv
sv/tmre_channels.sv
sv/tmre_ctrl.sv
sv/tmre_datapath.sv
sv/terminal_mouse_report_encoder.sv
sv/tmre_checker.sv
dv/terminal_mouse_report_encoder_test.sv
